FILE: rtl/b64e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the symbol-to-ASCII mapping shared by the base64
// stream encoder modules.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // Group position: bytes already taken in the current three-byte group
    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    // One classified byte: the symbols it completes and how many characters
    // (symbols followed by pads) it produces
    typedef struct packed {
        logic [5:0] sym0;
        logic [5:0] sym1;
        logic       two_syms;   // sym1 is a symbol, not a pad slot
        logic [1:0] last_idx;   // characters in the job minus one
        logic       eot;        // last character closes the message
    } t_job;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Map a 6-bit symbol to its ASCII character
    function automatic logic [6:0] sym_to_ascii(input logic [5:0] s);
        logic [6:0] s7;
        s7 = {1'b0, s};
        if (s < 6'd26) begin
            return s7 + 7'h41;
        end else if (s < 6'd52) begin
            return s7 - 7'd26 + 7'h61;
        end else if (s < 6'd62) begin
            return s7 - 7'd52 + 7'h30;
        end else if (s == 6'd62) begin
            return 7'h2B;
        end else begin
            return 7'h2F;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/b64e_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Takes raw bytes, tracks the group position and leftover bits, and turns
// each byte into a character job for the queue.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_final,
    input  wire t_q_stat    i_q_stat,
    output logic            o_ready,
    output logic            o_push,
    output t_job            o_job
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_left,  n_left;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && o_ready;

    // Classify the byte by group position
    always_comb begin
        o_job    = '0;
        n_phase  = r_phase;
        n_left   = r_left;
        case (r_phase)
            PHASE_ONE: begin
                o_job.sym0     = {r_left[1:0], i_byte[7:4]};
                o_job.sym1     = {i_byte[3:0], 2'b00};
                o_job.two_syms = i_final;
                o_job.last_idx = i_final ? 2'd2 : 2'd0;
                n_phase        = PHASE_TWO;
                n_left         = i_byte[3:0];
            end
            PHASE_TWO: begin
                o_job.sym0     = {r_left, i_byte[7:6]};
                o_job.sym1     = i_byte[5:0];
                o_job.two_syms = 1'b1;
                o_job.last_idx = 2'd1;
                n_phase        = PHASE_START;
                n_left         = 4'd0;
            end
            default: begin
                o_job.sym0     = i_byte[7:2];
                o_job.sym1     = {i_byte[1:0], 4'b0000};
                o_job.two_syms = i_final;
                o_job.last_idx = i_final ? 2'd3 : 2'd0;
                n_phase        = PHASE_ONE;
                n_left         = {2'b00, i_byte[1:0]};
            end
        endcase
        o_job.eot = i_final;
        // Return to group start at message end
        if (i_final) begin
            n_phase = PHASE_START;
            n_left  = 4'd0;
        end
    end

    // Advance the group state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_START;
            r_left  <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/b64e_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Small FIFO of character jobs between the byte front and the character
// back end. DEPTH must be a power of two, at least two.
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_q_stat   o_stat
);

    localparam int unsigned PW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_stat.full  = (r_count == (PW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];

    // Store incoming jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/b64e_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job into a registered output stage, one character per cycle
// while taken: symbols first, then '=' pads, end mark on the last of a message.
// ----------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job       i_job,
    input  wire t_q_stat    i_q_stat,
    output logic            o_pop,
    input  wire logic       i_ready,
    output logic            o_valid,
    output logic [6:0]      o_char,
    output logic            o_eot
);

    logic [1:0] r_pos,   n_pos;
    logic       r_valid, n_valid;
    logic [6:0] r_char,  n_char;
    logic       r_eot,   n_eot;
    logic       w_load;
    logic       w_is_last;
    logic [5:0] w_sym;

    assign w_load    = (!r_valid || i_ready) && !i_q_stat.empty;
    assign w_is_last = (r_pos == i_job.last_idx);
    assign o_pop     = w_load && w_is_last;
    assign w_sym     = r_pos[0] ? i_job.sym1 : i_job.sym0;

    // Pick the next character of the head job
    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_eot   = r_eot;
        if (w_load) begin
            n_valid = 1'b1;
            if (r_pos == 2'd0 || (r_pos == 2'd1 && i_job.two_syms)) begin
                n_char = sym_to_ascii(w_sym);
            end else begin
                n_char = PAD_CHAR;
            end
            n_eot = i_job.eot && w_is_last;
            n_pos = w_is_last ? 2'd0 : r_pos + 2'd1;
        end
    end

    // Hold the output stage until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_eot  <= n_eot;
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_eot   = r_eot;

endmodule
`default_nettype wire

FILE: rtl/base64_stream_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder: one raw byte in, one ASCII character out per
// transfer, with '=' padding and an end mark on the last character.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                      tlast
//  s_axis    in   [7:0] data_byte            final_byte
//  m_axis    out  [6:0] out_char, [7] zero   end_of_text
//
//  One character leaves per cycle while m_axis is ready; a byte yields 1 to 4
//  characters, so the output port sets the sustained byte rate (about 4
//  characters per 3 bytes). A byte's job is registered in the queue, and its
//  first character then in the output register.
//  The job queue (DEPTH entries, QUEUE_DEPTH by default) lets bytes enter while characters wait.
//  Synchronous active-low reset clears group state, queue and output valid.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic            m_axis_tlast
);

    t_job    w_push_job;
    t_job    w_head_job;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;
    logic [6:0] w_char;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .i_q_stat (w_q_stat),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    b64e_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_head_job),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_char   (w_char),
        .o_eot    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

`ifndef SYNTH
    // Never write a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_stat.full))
        else $error("job queue overflow");

    // Never retire a job from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_stat.empty))
        else $error("job queue underflow");

    // A full queue stalls the byte side on the next cycle unless a job retires
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.full && !w_pop) |=> !s_axis_tready)
        else $error("byte side not stalled on full queue");
`endif

endmodule
`default_nettype wire
